// ===== rtl/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;

  // working variables of the compression, a in the top bits
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } work_t;

  // control of the block buffer / schedule window
  typedef struct packed {
    logic load_byte;
    logic shift_word;
  } win_ctrl_t;

  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned DIGEST_W   = 160;

  localparam logic [ROUND_W-1:0] ROUNDS    = 7'd80;
  localparam logic [ROUND_W-1:0] ROUND_F1  = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_F2  = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_F3  = 7'd60;

  localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
  localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam work_t H_INIT = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

endpackage

`default_nettype wire

// ===== rtl/sha1_hash_engine_unit.sv =====
`default_nettype none

// Streaming SHA-1 (160-bit digest). Each input item is one message byte
// (tuser low) or a finish request (tuser high). The 64th byte of a block
// starts the compression, which runs one round per cycle through a single
// round unit and then folds the working variables into the hash words.
// A finish shifts the padding and the big-endian bit length in one byte per
// cycle, compresses once (when the length fits behind the pad mark) or twice
// (when a second block is needed), and then places the digest on the output.
// Input ready is low while a block or a finish is in progress.
// The digest sits in an output register, so bytes of the next message are
// taken while it waits; the digest of a second finish waits for it.
// After a finish the engine starts a new message.
module sha1_hash_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] data_byte
  input  logic                          s_axis_tuser_i,  // [0] mode
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] digest_word0, [63:32] digest_word1, [95:64] digest_word2,
  // [127:96] digest_word3, [159:128] digest_word4
  output logic [sha1_pkg::DIGEST_W-1:0] m_axis_tdata_o
);
  import sha1_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [63:0]         bit_count_q, bit_count_d;
  logic [ROUND_W-1:0]  round_q, round_d;
  logic                fin_q, fin_d;
  logic                mark_q, mark_d;
  logic                len_ok_q, len_ok_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  work_t               hash_q, hash_d;
  work_t               work_q, work_d;
  logic [DIGEST_W-1:0] out_q, out_d;

  win_ctrl_t           win_ctrl;
  logic [7:0]          win_byte;
  word_t               w_cur;
  work_t               round_out;
  logic [63:0]         len_shift;
  logic [7:0]          pad_byte;
  logic                emit_go;

  sha1_window u_window (
    .clk_i  (clk_i),
    .ctrl_i (win_ctrl),
    .byte_i (win_byte),
    .w_o    (w_cur)
  );

  sha1_round u_round (
    .work_i  (work_q),
    .w_i     (w_cur),
    .round_i (round_q),
    .work_o  (round_out)
  );

  // length byte for position 56 + k is byte 7 - k of the bit count
  assign len_shift = bit_count_q >> {~fill_q[2:0], 3'b000};

  always_comb begin
    priority if (!mark_q) begin
      pad_byte = PAD_MARK;
    end else if (len_ok_q && (fill_q >= LEN_POS)) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bit_count_d = bit_count_q;
    round_d     = round_q;
    fin_d       = fin_q;
    mark_d      = mark_q;
    len_ok_d    = len_ok_q;
    last_d      = last_q;
    hash_d      = hash_q;
    work_d      = work_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    win_ctrl    = '0;
    win_byte    = s_axis_tdata_i;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (!s_axis_tuser_i) begin
            win_ctrl.load_byte = 1'b1;
            fill_d             = fill_q + 1'b1;
            bit_count_d        = bit_count_q + 64'd8;
            if (fill_q == FILL_LAST) begin
              work_d  = hash_q;
              round_d = '0;
              state_d = ST_ROUND;
            end
          end else begin
            fin_d    = 1'b1;
            mark_d   = 1'b0;
            len_ok_d = 1'b0;
            last_d   = 1'b0;
            state_d  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        win_ctrl.load_byte = 1'b1;
        win_byte           = pad_byte;
        fill_d             = fill_q + 1'b1;
        if (!mark_q) begin
          mark_d = 1'b1;
          if (fill_q < LEN_POS) begin
            len_ok_d = 1'b1;
          end
        end
        if (fill_q == FILL_LAST) begin
          // the block after an overflow block always carries the length
          last_d   = len_ok_q;
          len_ok_d = 1'b1;
          work_d   = hash_q;
          round_d  = '0;
          state_d  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        win_ctrl.shift_word = 1'b1;
        work_d              = round_out;
        round_d             = round_q + 1'b1;
        if (round_q == ROUNDS - 1'b1) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        hash_d.a = hash_q.a + work_q.a;
        hash_d.b = hash_q.b + work_q.b;
        hash_d.c = hash_q.c + work_q.c;
        hash_d.d = hash_q.d + work_q.d;
        hash_d.e = hash_q.e + work_q.e;
        priority if (fin_q && last_q) begin
          state_d = ST_EMIT;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_d       = {hash_q.e, hash_q.d, hash_q.c, hash_q.b, hash_q.a};
          out_valid_d = 1'b1;
          hash_d      = H_INIT;
          bit_count_d = '0;
          fin_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bit_count_q <= '0;
      round_q     <= '0;
      fin_q       <= 1'b0;
      mark_q      <= 1'b0;
      len_ok_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      hash_q      <= H_INIT;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bit_count_q <= bit_count_d;
      round_q     <= round_d;
      fin_q       <= fin_d;
      mark_q      <= mark_d;
      len_ok_q    <= len_ok_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      hash_q      <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    out_q  <= out_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (round_q < ROUNDS))
    else $error("round counter out of range");

  a_block_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_ROUND) && ($past(state_q) != ST_ROUND)) |-> (fill_q == '0))
    else $error("compression started off a block boundary");

  a_idle_no_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !fin_q)
    else $error("finish flag left set while idle");

  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> ((bit_count_q == '0) && (fill_q == '0) && m_axis_tvalid_o))
    else $error("digest emitted without restarting the message");
`endif

endmodule

`default_nettype wire

// ===== rtl/sha1_round.sv =====
`default_nettype none

module sha1_round (
  input  sha1_pkg::work_t                     work_i,
  input  sha1_pkg::word_t                     w_i,
  input  logic [sha1_pkg::ROUND_W-1:0]        round_i,
  output sha1_pkg::work_t                     work_o
);
  import sha1_pkg::*;

  word_t f;
  word_t k;

  always_comb begin
    priority if (round_i < ROUND_F1) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = K0;
    end else if (round_i < ROUND_F2) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K1;
    end else if (round_i < ROUND_F3) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K3;
    end
  end

  always_comb begin
    work_o.a = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + w_i + k;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_window.sv =====
`default_nettype none

// Block buffer that turns into the message schedule window: bytes shift in at
// the bottom, and during the rounds the top word is the current schedule word.
module sha1_window (
  input  logic                 clk_i,
  input  sha1_pkg::win_ctrl_t  ctrl_i,
  input  logic [7:0]           byte_i,
  output sha1_pkg::word_t      w_o
);
  import sha1_pkg::*;

  logic [BLOCK_BITS-1:0] win_q, win_d;
  word_t                 w_next;

  // W[t+16] from W[t+13], W[t+8], W[t+2], W[t]
  always_comb begin
    word_t x;
    x = win_q[BLOCK_BITS-1-32*13 -: 32] ^ win_q[BLOCK_BITS-1-32*8 -: 32]
      ^ win_q[BLOCK_BITS-1-32*2 -: 32] ^ win_q[BLOCK_BITS-1 -: 32];
    w_next = {x[30:0], x[31]};
  end

  always_comb begin
    win_d = win_q;
    if (ctrl_i.load_byte) begin
      win_d = {win_q[BLOCK_BITS-9:0], byte_i};
    end else if (ctrl_i.shift_word) begin
      win_d = {win_q[BLOCK_BITS-33:0], w_next};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o = win_q[BLOCK_BITS-1 -: 32];

endmodule

`default_nettype wire
